// ===== hw/rtl/make_before_break_shift_switcher_assert.svh =====
`ifndef MAKE_BEFORE_BREAK_SHIFT_SWITCHER_ASSERT_SVH
`define MAKE_BEFORE_BREAK_SHIFT_SWITCHER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define MBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MBB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/mbb_pkg.sv =====
package mbb_pkg;

  localparam int IDX_W = 5;

  typedef enum logic [1:0] {
    CMD_SWITCH = 2'd0,
    CMD_FIELD  = 2'd1,
    CMD_EXEC   = 2'd2,
    CMD_NONE   = 2'd3
  } mbb_cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_ON,
    OP_CLR_OFF,
    OP_FIELD,
    OP_MAKE,
    OP_BREAK
  } mbb_op_t;

  typedef struct packed {
    mbb_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [7:0]       on_bits;
    logic [7:0]       flip_bits;
    logic             latch;
    logic             fin;
  } mbb_req_t;

endpackage

// ===== hw/rtl/make_before_break_shift_switcher.sv =====
// Make-before-break driver for a chain of NUM_SHIFT_REGS 8-bit shift registers.
// The input channel takes one request at a time: a single switch, a field of up
// to eight bits at any bit position, or an execute request.
// A switch request runs through ST_SWITCH and a field request through
// ST_FIELD_LO and ST_FIELD_HI, with in_stall high meanwhile; a field of width
// zero and an unknown command leave the block idle. None of these causes a
// result.
// An execute request sends 2 * NUM_SHIFT_REGS results on the output channel,
// one byte per cycle while the receiver does not stall; the first passes
// through the sequencer state ST_MAKE and then the output register.
// The make phase sends every byte, index 0 first, with the pending closures
// applied, and the break phase sends them again with the pending openings
// applied; latch_after marks the last byte of each phase and last the end.
// Results come from one output register; a stall holds it, and the sequencer
// waits for it to free before producing the next byte.
// Reset opens every switch, clears all pending changes and idles the block.
module make_before_break_shift_switcher #(
  parameter int NUM_SHIFT_REGS = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [6:0] in_bit_position,
  input  logic [3:0] in_field_width,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_shift_byte,
  output logic       out_phase,
  output logic       out_latch_after,
  output logic       out_last
);
  import mbb_pkg::*;

  `include "make_before_break_shift_switcher_assert.svh"

  mbb_req_t   req;
  logic [7:0] byte_out;
  logic       out_free;
  logic       emit;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       phase_r;
  logic       latch_r;
  logic       last_r;

  assign out_free = !valid_r || !out_stall;
  assign emit     = (req.op == OP_MAKE) || (req.op == OP_BREAK);

  mbb_ctrl #(
    .NUM_SHIFT_REGS(NUM_SHIFT_REGS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_bit_position(in_bit_position),
    .in_field_width (in_field_width),
    .in_value       (in_value),
    .out_free       (out_free),
    .req            (req)
  );

  mbb_bank #(
    .NUM_SHIFT_REGS(NUM_SHIFT_REGS)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .byte_out(byte_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (emit) begin
      byte_r  <= byte_out;
      phase_r <= (req.op == OP_BREAK);
      latch_r <= req.latch;
      last_r  <= req.fin;
    end
  end

  assign out_valid       = valid_r;
  assign out_shift_byte  = byte_r;
  assign out_phase       = phase_r;
  assign out_latch_after = latch_r;
  assign out_last        = last_r;

  `MBB_ASSERT(a_last_ends_break, (out_valid && out_last |-> out_latch_after && out_phase), "last byte must close the break phase")
  `MBB_ASSERT(a_exec_busy, (in_valid && !in_stall && in_command == CMD_EXEC |=> in_stall), "execute request must keep the block busy")
  `MBB_ASSERT(a_break_order, (out_valid && !out_stall && out_phase && !out_last |=> !out_valid || out_phase), "break phase byte followed by a make phase byte")
  `MBB_ASSERT_ALWAYS(a_reset_idle, (!rst_n |=> !out_valid && !in_stall), "block must be idle after reset")

endmodule

// ===== hw/rtl/mbb_ctrl.sv =====
module mbb_ctrl #(
  parameter int NUM_SHIFT_REGS = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [6:0]        in_bit_position,
  input  logic [3:0]        in_field_width,
  input  logic [7:0]        in_value,
  input  logic              out_free,
  output mbb_pkg::mbb_req_t req
);
  import mbb_pkg::*;

  localparam int CW = (NUM_SHIFT_REGS > 1) ? $clog2(NUM_SHIFT_REGS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWITCH,
    ST_FIELD_LO,
    ST_FIELD_HI,
    ST_MAKE,
    ST_BREAK
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [6:0]      pos_r;
  logic [3:0]      width_r;
  logic [7:0]      val_r;
  logic            accept;
  logic            cnt_end;
  logic [3:0]      weff;
  logic [7:0]      mask;
  logic [7:0]      vbits;
  logic [15:0]     on16;
  logic [15:0]     x16;
  logic [IDX_W-1:0] base_idx;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cnt_end  = (cnt_r == CW'(NUM_SHIFT_REGS - 1));
  assign weff     = (width_r > 4'd8) ? 4'd8 : width_r;
  assign mask     = 8'hFF >> (4'd8 - weff);
  assign vbits    = val_r & mask;
  assign on16     = {8'h00, vbits} << pos_r[2:0];
  assign x16      = {8'h00, mask ^ vbits} << pos_r[2:0];
  assign base_idx = IDX_W'(pos_r[6:3]);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    req       = '0;
    req.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          case (mbb_cmd_t'(in_command))
            CMD_SWITCH: state_nxt = ST_SWITCH;
            CMD_FIELD:  state_nxt = (in_field_width == 4'd0) ? ST_IDLE : ST_FIELD_LO;
            CMD_EXEC:   state_nxt = ST_MAKE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SWITCH: begin
        req.op        = val_r[0] ? OP_SET_ON : OP_CLR_OFF;
        req.idx       = base_idx;
        req.on_bits   = 8'h01 << pos_r[2:0];
        req.flip_bits = 8'h01 << pos_r[2:0];
        state_nxt     = ST_IDLE;
      end
      ST_FIELD_LO: begin
        req.op        = OP_FIELD;
        req.idx       = base_idx;
        req.on_bits   = on16[7:0];
        req.flip_bits = x16[7:0];
        state_nxt     = ST_FIELD_HI;
      end
      ST_FIELD_HI: begin
        req.op        = OP_FIELD;
        req.idx       = base_idx + IDX_W'(1);
        req.on_bits   = on16[15:8];
        req.flip_bits = x16[15:8];
        state_nxt     = ST_IDLE;
      end
      ST_MAKE: begin
        if (out_free) begin
          req.op    = OP_MAKE;
          req.idx   = IDX_W'(cnt_r);
          req.latch = cnt_end;
          if (cnt_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_BREAK;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_BREAK: begin
        if (out_free) begin
          req.op    = OP_BREAK;
          req.idx   = IDX_W'(cnt_r);
          req.latch = cnt_end;
          req.fin   = cnt_end;
          if (cnt_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    if (accept) begin
      pos_r   <= in_bit_position;
      width_r <= in_field_width;
      val_r   <= in_value;
    end
  end

endmodule

// ===== hw/rtl/mbb_bank.sv =====
module mbb_bank #(
  parameter int NUM_SHIFT_REGS = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mbb_pkg::mbb_req_t req,
  output logic [7:0]        byte_out
);
  import mbb_pkg::*;

  localparam int CW = (NUM_SHIFT_REGS > 1) ? $clog2(NUM_SHIFT_REGS) : 1;

  logic [7:0]    pend_on_r  [NUM_SHIFT_REGS];
  logic [7:0]    pend_off_r [NUM_SHIFT_REGS];
  logic [7:0]    cur_r      [NUM_SHIFT_REGS];
  logic [CW-1:0] addr;
  logic          in_range;
  logic [7:0]    rd_on;
  logic [7:0]    rd_off;
  logic [7:0]    rd_cur;

  assign in_range = ({1'b0, req.idx} < (IDX_W + 1)'(NUM_SHIFT_REGS));
  assign addr     = in_range ? req.idx[CW-1:0] : '0;
  assign rd_on    = pend_on_r[addr];
  assign rd_off   = pend_off_r[addr];
  assign rd_cur   = cur_r[addr];
  assign byte_out = (req.op == OP_BREAK) ? (rd_cur & rd_off) : (rd_cur | rd_on);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SHIFT_REGS; i++) begin
        pend_on_r[i]  <= 8'h00;
        pend_off_r[i] <= 8'hFF;
        cur_r[i]      <= 8'h00;
      end
    end else if (in_range) begin
      case (req.op)
        OP_SET_ON:  pend_on_r[addr] <= rd_on | req.on_bits;
        OP_CLR_OFF: pend_off_r[addr] <= rd_off & ~req.flip_bits;
        OP_FIELD: begin
          pend_on_r[addr]  <= rd_on | req.on_bits;
          pend_off_r[addr] <= rd_off ^ req.flip_bits;
        end
        OP_MAKE:  cur_r[addr] <= byte_out;
        OP_BREAK: begin
          cur_r[addr] <= byte_out;
          if (req.fin) begin
            for (int i = 0; i < NUM_SHIFT_REGS; i++) begin
              pend_on_r[i]  <= 8'h00;
              pend_off_r[i] <= 8'hFF;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
